// File: hdl/epcd_pkg.sv
// package for the directed euler path / circuit checker
// holds sizes, transaction structs and sequencer state codes; no dependencies
`timescale 1ns / 1ps
package epcd_pkg;
   localparam int NODE_COUNT    = 64;
   localparam int EDGE_CAPACITY = 256;
   localparam int NODE_W  = 6;
   localparam int NIDX_W  = $clog2(NODE_COUNT);
   localparam int EIDX_W  = $clog2(EDGE_CAPACITY);
   localparam int ECNT_W  = $clog2(EDGE_CAPACITY + 1);
   localparam int DEG_W   = ECNT_W;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [NODE_W-1:0] src_node;
      logic [NODE_W-1:0] dst_node;
   } req_type;

   typedef struct packed {
      logic has_path;
      logic has_circuit;
      logic overflowed;
   } rsp_type;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_FIND   = 8'b00000010,
      ST_SWEEP  = 8'b00000100,
      ST_CHECK  = 8'b00001000,
      ST_REPLY  = 8'b00010000,
      ST_CLEAR  = 8'b00100000,
      ST_EWAIT  = 8'b01000000,
      ST_ADD    = 8'b10000000
   } state_type;
endpackage

// File: hdl/epcd_edge_ram.sv
// edge store: one write port, one registered read port
// depends on epcd_pkg for sizes
`timescale 1ns / 1ps
module epcd_edge_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [epcd_pkg::EIDX_W-1:0]   wr_addr,
   input  logic [2*epcd_pkg::NODE_W-1:0] wr_data,
   input  logic [epcd_pkg::EIDX_W-1:0]   rd_addr,
   output logic [2*epcd_pkg::NODE_W-1:0] rd_data
);
   import epcd_pkg::*;

   logic [2*NODE_W-1:0] mem [EDGE_CAPACITY];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hdl/euler_path_check_directed.sv
// Directed Eulerian path / circuit checker. After reset the block runs a clearing pass of
// its degree counters with busy high. An add transaction (operation 0) stores one edge:
// busy then stays high in the ST_ADD state while the degree counters of its two nodes are
// incremented, so no new transaction is accepted during that update; an add that finds the
// store full is dropped and busy stays low. An evaluate transaction raises busy and runs a
// sequencer: a scan of up to 64 nodes that stops at the first node with an edge, then, if
// one is found, repeated sweeps of the edge store through the single read port of the edge
// memory until a sweep marks nothing new, then a node pass for connectivity and degree
// balance, a reply state and a clearing pass of the degree counters. After an overflow the
// scan, sweeps and node pass are skipped. The result sits on rsp_ for exactly one cycle
// with rsp_valid, the first clearing cycle; the receiver cannot stall it.
// depends on epcd_pkg and epcd_edge_ram
`timescale 1ns / 1ps
module euler_path_check_directed (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  epcd_pkg::req_type req_data,
   output logic              rsp_valid,
   output epcd_pkg::rsp_type rsp_data
);
   import epcd_pkg::*;

   state_type state_ff, state_in;
   logic [ECNT_W-1:0] total_ff, total_in;
   logic              drop_ff, drop_in;
   logic [NIDX_W-1:0] node_ff, node_in;
   logic [ECNT_W-1:0] eidx_ff, eidx_in;
   logic              changed_ff, changed_in;
   logic              rvalid_ff, rvalid_in;
   logic              bad_ff, bad_in;
   logic [1:0]        starts_ff, starts_in, ends_ff, ends_in;
   logic [NODE_COUNT-1:0] reach_ff, reach_in;
   logic [NIDX_W-1:0] add_src_ff, add_src_in, add_dst_ff, add_dst_in;
   logic [DEG_W-1:0]  in_cnt [NODE_COUNT];
   logic [DEG_W-1:0]  out_cnt [NODE_COUNT];
   logic [DEG_W-1:0]  in_rd_ff, out_rd_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic accept, add_ok, store_full;
   logic [2*NODE_W-1:0] rd_data;
   logic [NIDX_W-1:0] ra, rb;
   logic [NIDX_W-1:0] in_raddr, out_raddr;
   logic [DEG_W-1:0] ci, co;
   logic active;

   assign accept     = start && !busy;
   assign store_full = (total_ff == ECNT_W'(EDGE_CAPACITY));
   assign add_ok     = accept && req_data.operation == OP_ADD && !store_full;
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign ra = rd_data[2*NODE_W-1 -: NIDX_W];
   assign rb = rd_data[NIDX_W-1:0];
   assign ci = in_rd_ff;
   assign co = out_rd_ff;
   assign active = (ci != '0) || (co != '0);

   // counter read address: the nodes of an add, else the node the sequencer moves to
   assign out_raddr = add_ok ? req_data.src_node : node_in;
   assign in_raddr  = add_ok ? req_data.dst_node : node_in;

   epcd_edge_ram u_ram (
      .clock   (clock),
      .wr_en   (add_ok),
      .wr_addr (total_ff[EIDX_W-1:0]),
      .wr_data ({req_data.src_node, req_data.dst_node}),
      .rd_addr (eidx_ff[EIDX_W-1:0]),
      .rd_data (rd_data)
   );

   // degree counters: registered read, bump the cycle after an add, zero on the clearing pass
   always_ff @(posedge clock) begin
      if (state_ff == ST_ADD) begin
         out_cnt[add_src_ff] <= out_rd_ff + 1'b1;
         in_cnt[add_dst_ff]  <= in_rd_ff + 1'b1;
      end else if (state_ff == ST_CLEAR) begin
         in_cnt[node_ff]  <= '0;
         out_cnt[node_ff] <= '0;
      end
      out_rd_ff <= out_cnt[out_raddr];
      in_rd_ff  <= in_cnt[in_raddr];
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      total_in   = total_ff;
      drop_in    = drop_ff;
      node_in    = node_ff;
      eidx_in    = eidx_ff;
      changed_in = changed_ff;
      rvalid_in  = 1'b0;
      bad_in     = bad_ff;
      starts_in  = starts_ff;
      ends_in    = ends_ff;
      reach_in   = reach_ff;
      add_src_in = add_src_ff;
      add_dst_in = add_dst_ff;
      rsp_in     = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.operation == OP_ADD) begin
               if (store_full) drop_in = 1'b1;
               else begin
                  total_in   = total_ff + 1'b1;
                  add_src_in = req_data.src_node;
                  add_dst_in = req_data.dst_node;
                  state_in   = ST_ADD;
               end
            end else if (accept) begin
               node_in  = '0;
               reach_in = '0;
               state_in = drop_ff ? ST_REPLY : ST_FIND;
               rsp_in   = '{has_path: 1'b0, has_circuit: 1'b0, overflowed: drop_ff};
            end
         end
         // counters of the added edge are written this cycle
         ST_ADD: begin
            state_in = ST_IDLE;
         end
         // first active node seeds the flood
         ST_FIND: begin
            if (active) begin
               reach_in[node_ff] = 1'b1;
               eidx_in    = '0;
               changed_in = 1'b0;
               state_in   = ST_SWEEP;
            end else if (node_ff == NIDX_W'(NODE_COUNT - 1)) begin
               node_in  = '0;
               state_in = ST_CHECK;
            end else begin
               node_in = node_ff + 1'b1;
            end
            bad_in = 1'b0; starts_in = '0; ends_in = '0;
         end
         // one edge per cycle, read data comes from the registered read port and is marked by rvalid_ff
         ST_SWEEP: begin
            if (rvalid_ff && reach_ff[ra] != reach_ff[rb]) begin
               reach_in[ra] = 1'b1;
               reach_in[rb] = 1'b1;
               changed_in   = 1'b1;
            end
            if (eidx_ff < total_ff) begin
               eidx_in   = eidx_ff + 1'b1;
               rvalid_in = 1'b1;
            end else begin
               state_in = ST_EWAIT;
            end
         end
         ST_EWAIT: begin
            if (changed_ff || (rvalid_ff && reach_ff[ra] != reach_ff[rb])) begin
               eidx_in = '0; changed_in = 1'b0; state_in = ST_SWEEP;
            end else begin
               node_in = '0; state_in = ST_CHECK;
            end
         end
         // connectivity and balance per node
         ST_CHECK: begin
            if (active && !reach_ff[node_ff]) bad_in = 1'b1;
            if (co == ci + 1'b1) starts_in = (starts_ff == 2'd2) ? 2'd2 : starts_ff + 1'b1;
            else if (ci == co + 1'b1) ends_in = (ends_ff == 2'd2) ? 2'd2 : ends_ff + 1'b1;
            else if (ci != co) bad_in = 1'b1;
            if (node_ff == NIDX_W'(NODE_COUNT - 1)) state_in = ST_REPLY;
            else node_in = node_ff + 1'b1;
         end
         ST_REPLY: begin
            if (!drop_ff) begin
               rsp_in.has_path    = !bad_ff && ((starts_ff == 2'd0 && ends_ff == 2'd0) ||
                                               (starts_ff == 2'd1 && ends_ff == 2'd1));
               rsp_in.has_circuit = !bad_ff && starts_ff == 2'd0 && ends_ff == 2'd0;
            end
            node_in  = '0;
            state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            total_in = '0;
            drop_in  = 1'b0;
            if (node_ff == NIDX_W'(NODE_COUNT - 1)) state_in = ST_IDLE;
            else node_in = node_ff + 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // reset starts a clearing pass of the degree counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         node_ff      <= '0;
         total_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rvalid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         total_ff     <= total_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= (state_ff == ST_REPLY);
         rvalid_ff    <= rvalid_in;
      end
      eidx_ff    <= eidx_in;
      changed_ff <= changed_in;
      bad_ff     <= bad_in;
      starts_ff  <= starts_in;
      ends_ff    <= ends_in;
      reach_ff   <= reach_in;
      add_src_ff <= add_src_in;
      add_dst_ff <= add_dst_in;
      rsp_ff     <= rsp_in;
   end

   // checks
   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      total_ff <= ECNT_W'(EDGE_CAPACITY)) else $error("edge count past capacity");
   a_rsp_after_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_REPLY) else $error("stray response");
   a_ovf_no_path: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflowed |-> !rsp_data.has_path && !rsp_data.has_circuit)
      else $error("overflow with answer");
   a_circ_path: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.has_circuit |-> rsp_data.has_path) else $error("circuit no path");
endmodule

// File: verif/euler_path_check_directed_tb.sv
// testbench for the directed euler path / circuit checker
// self-checking: own degree/connectivity predictor, random stimulus; depends on epcd_pkg
`timescale 1ns / 1ps
module euler_path_check_directed_tb;
   import epcd_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   euler_path_check_directed dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: edge list and drop flag
   logic [NODE_W-1:0] graph_src[$];
   logic [NODE_W-1:0] graph_dst[$];
   bit                graph_dropped;

   req_type pending_items[$];
   rsp_type expected_answers[$];
   int      mismatch_count = 0;
   bit      stimulus_done = 1'b0;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // predicts the answer for the current graph, then clears it
   function automatic rsp_type evaluate_graph();
      rsp_type answer;
      int in_deg[NODE_COUNT];
      int out_deg[NODE_COUNT];
      bit marked[NODE_COUNT];
      bit changed;
      bit connected;
      bit unbalanced;
      int first_node;
      int starts;
      int ends;
      answer = '0;
      answer.overflowed = graph_dropped;
      foreach (in_deg[n]) begin
         in_deg[n] = 0;
         out_deg[n] = 0;
         marked[n] = 1'b0;
      end
      foreach (graph_src[e]) begin
         out_deg[graph_src[e]]++;
         in_deg[graph_dst[e]]++;
      end
      first_node = -1;
      for (int n = 0; n < NODE_COUNT; n++)
         if (first_node < 0 && in_deg[n] + out_deg[n] > 0) first_node = n;
      connected = 1'b1;
      if (first_node >= 0) begin
         marked[first_node] = 1'b1;
         do begin
            changed = 1'b0;
            foreach (graph_src[e])
               if (marked[graph_src[e]] != marked[graph_dst[e]]) begin
                  marked[graph_src[e]] = 1'b1;
                  marked[graph_dst[e]] = 1'b1;
                  changed = 1'b1;
               end
         end while (changed);
         for (int n = 0; n < NODE_COUNT; n++)
            if (in_deg[n] + out_deg[n] > 0 && !marked[n]) connected = 1'b0;
      end
      if (!graph_dropped && connected) begin
         starts = 0;
         ends = 0;
         unbalanced = 1'b0;
         for (int n = 0; n < NODE_COUNT; n++) begin
            if (out_deg[n] == in_deg[n] + 1) starts++;
            else if (in_deg[n] == out_deg[n] + 1) ends++;
            else if (in_deg[n] != out_deg[n]) unbalanced = 1'b1;
         end
         if (!unbalanced && starts == 0 && ends == 0) begin
            answer.has_path = 1'b1;
            answer.has_circuit = 1'b1;
         end else if (!unbalanced && starts == 1 && ends == 1) begin
            answer.has_path = 1'b1;
         end
      end
      graph_src.delete();
      graph_dst.delete();
      graph_dropped = 1'b0;
      return answer;
   endfunction

   // applies one accepted transaction to the predictor
   function automatic void predict_transaction(input req_type item);
      if (item.operation == OP_EVAL) begin
         expected_answers.insert(expected_answers.size(), evaluate_graph());
      end else if (graph_src.size() >= EDGE_CAPACITY) begin
         graph_dropped = 1'b1;
      end else begin
         graph_src.insert(graph_src.size(), item.src_node);
         graph_dst.insert(graph_dst.size(), item.dst_node);
      end
   endfunction

   function automatic req_type make_edge(input int s, input int d);
      req_type item;
      item.operation = OP_ADD;
      item.src_node = NODE_W'(s);
      item.dst_node = NODE_W'(d);
      return item;
   endfunction

   function automatic req_type make_eval();
      req_type item;
      item.operation = OP_EVAL;
      item.src_node = NODE_W'($urandom);
      item.dst_node = NODE_W'($urandom);
      return item;
   endfunction

   // appends one transaction to the driver queue
   function automatic void enqueue_item(input req_type item);
      pending_items.insert(pending_items.size(), item);
   endfunction

   // driver: gap before each transaction, hold start until accepted
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= $urandom_range(0, 16);
      end else if (start && !busy) begin
         predict_transaction(req_data);
         start <= 1'b0;
         gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end else if (!start && gap_left > 0) begin
         gap_left <= gap_left - 1;
      end else if (!start && pending_items.size() > 0) begin
         req_data <= pending_items.pop_front();
         start <= 1'b1;
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            rsp_type want;
            want = expected_answers.pop_front();
            if (rsp_data.has_path !== want.has_path)
               report_mismatch($sformatf("has_path %b want %b",
                  rsp_data.has_path, want.has_path));
            if (rsp_data.has_circuit !== want.has_circuit)
               report_mismatch($sformatf("has_circuit %b want %b",
                  rsp_data.has_circuit, want.has_circuit));
            if (rsp_data.overflowed !== want.overflowed)
               report_mismatch($sformatf("overflowed %b want %b",
                  rsp_data.overflowed, want.overflowed));
         end
      end
   end

   // stimulus
   initial begin
      int count;
      int nodes[$];
      int len;
      int a;
      graph_dropped = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty graph, self loop, extremes, path, unbalanced, split, overflow
      enqueue_item(make_eval());
      enqueue_item(make_edge(63, 63));
      enqueue_item(make_eval());
      enqueue_item(make_edge(0, 63));
      enqueue_item(make_eval());
      enqueue_item(make_edge(0, 63));
      enqueue_item(make_edge(63, 0));
      enqueue_item(make_eval());
      enqueue_item(make_edge(0, 1));
      enqueue_item(make_edge(0, 2));
      enqueue_item(make_eval());
      enqueue_item(make_edge(1, 2));
      enqueue_item(make_edge(2, 1));
      enqueue_item(make_edge(5, 6));
      enqueue_item(make_edge(6, 5));
      enqueue_item(make_eval());
      enqueue_item(make_edge(42, 21));
      enqueue_item(make_edge(21, 42));
      enqueue_item(make_eval());
      for (int i = 0; i < EDGE_CAPACITY + 2; i++)
         enqueue_item(make_edge(i % 2, (i + 1) % 2));
      enqueue_item(make_eval());

      // random: mostly walks (near-Eulerian) with noise, small graphs
      count = 0;
      while (count < 350) begin
         nodes.delete();
         len = $urandom_range(1, 12);
         for (int i = 0; i < $urandom_range(2, 8); i++)
            nodes.insert(nodes.size(), $urandom_range(0, 63));
         a = nodes[$urandom_range(0, nodes.size() - 1)];
         for (int i = 0; i < len; i++) begin
            int b;
            b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                : nodes[$urandom_range(0, nodes.size() - 1)];
            if ($urandom_range(0, 7) == 0)
               enqueue_item(make_edge($urandom_range(0, 63), b));
            else
               enqueue_item(make_edge(a, b));
            a = b;
            count++;
         end
         if ($urandom_range(0, 1) == 0) begin
            enqueue_item(make_edge(a, nodes[0]));
            count++;
         end
         enqueue_item(make_eval());
         count++;
      end
      // two full stores with random content
      repeat (2) begin
         repeat (EDGE_CAPACITY + $urandom_range(0, 3))
            enqueue_item(make_edge($urandom_range(0, 63), $urandom_range(0, 63)));
         enqueue_item(make_eval());
      end

      wait (pending_items.size() == 0 && !start);
      wait (expected_answers.size() == 0);
      repeat (2000) @(posedge clock);
      stimulus_done = 1'b1;
      if (mismatch_count == 0 && expected_answers.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #50ms;
      if (!stimulus_done) begin
         $display("TEST FAILED");
         $finish;
      end
   end
endmodule
